// ===== hdl/wst_pkg.sv =====
// Package for the windowed slope tracker: sizes, constant tables, state and code types.
`timescale 1ns / 1ps

package wst_pkg;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Window geometry
    localparam int WINDOW    = 8;
    localparam int WIN_IDX_W = $clog2(WINDOW);
    localparam int CNT_W     = $clog2(WINDOW + 1);

    // Field widths
    localparam int SMP_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int Y_W     = SMP_W + FRAC_W;
    localparam int THR_W   = 31;
    localparam int SCALE_W = 32;
    localparam int SLOPE_W = 32;
    localparam int DIR_W   = 2;

    // Smoothing: running sum plus rounding term, divided via reciprocal
    localparam int SUM_W = Y_W + $clog2(WINDOW);
    localparam int RCP_K = SUM_W + $clog2(WINDOW);
    localparam int RCP_W = RCP_K + 1;

    // Fit: per-element weight W*x - sum(x)
    localparam int SX    = WINDOW * (WINDOW - 1) / 2;
    localparam int C_W   = $clog2(SX + 1);
    localparam int NUM_W = Y_W + $clog2(WINDOW * SX + 1) + 1;

    // Scaling: magnitude taken 16 bits at a time, most significant first
    localparam int CHUNK_W   = 16;
    localparam int NCHUNK    = (NUM_W + CHUNK_W - 1) / CHUNK_W;
    localparam int CHK_IDX_W = $clog2(NCHUNK);
    localparam int MAG_PAD_W = NCHUNK * CHUNK_W;
    localparam int ACC_W     = MAG_PAD_W + SCALE_W;
    localparam int RND_SH    = 16;
    localparam int RV_W      = ACC_W - RND_SH;

    // Shared multiplier
    localparam int MUL_A_W = f_max(SUM_W, f_max(Y_W, CHUNK_W));
    localparam int MUL_B_W = f_max(RCP_W, f_max(SCALE_W, C_W));
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Sequencer index covers window entries and magnitude chunks
    localparam int IDX_W = f_max(WIN_IDX_W, CHK_IDX_W);

    // Register reset values and slope limits
    localparam logic [THR_W-1:0]   THR_RESET   = '0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;
    localparam logic [ACC_W-1:0]   ROUND_HALF  = ACC_W'(1) << (RND_SH - 1);
    localparam logic [SLOPE_W-1:0] SLOPE_POS_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_NEG_MAX = {1'b1, {(SLOPE_W-1){1'b0}}};

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAT_THRESHOLD = 2'd0,
        CFG_SLOPE_SCALE    = 2'd1
    } t_cfg_reg;

    // Direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_FLAT = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SM_MUL,
        S_SM_ACC,
        S_FIT_MUL,
        S_FIT_ACC,
        S_ABS,
        S_SC_MUL,
        S_SC_ACC,
        S_ROUND,
        S_DONE
    } t_state;

    typedef logic [RCP_W-1:0] t_rcp_tbl [WINDOW];
    typedef logic [C_W-1:0]   t_coef_tbl [WINDOW];

    // ceil(2^K / n) for n = 1..WINDOW, by long division of 2^K - 1
    function automatic t_rcp_tbl f_rcp_tbl();
        t_rcp_tbl          tbl;
        longint unsigned   rem;
        longint unsigned   quo;
        longint unsigned   n;
        for (int i = 0; i < WINDOW; i++) begin
            n   = longint'(i + 1);
            rem = 0;
            quo = 0;
            for (int b = RCP_K - 1; b >= 0; b--) begin
                rem = (rem << 1) | 64'd1;
                if (rem >= n) begin
                    rem = rem - n;
                    quo = quo | (64'd1 << b);
                end
            end
            tbl[i] = RCP_W'(quo + 64'd1);
        end
        return tbl;
    endfunction

    // |W*x - SX| for window entry i, where x = W-1-i
    function automatic t_coef_tbl f_coef_mag();
        t_coef_tbl tbl;
        int        c;
        for (int i = 0; i < WINDOW; i++) begin
            c      = WINDOW * (WINDOW - 1 - i) - SX;
            tbl[i] = C_W'((c < 0) ? -c : c);
        end
        return tbl;
    endfunction

    // Sign of W*x - SX for window entry i
    function automatic logic [WINDOW-1:0] f_coef_neg();
        logic [WINDOW-1:0] bits;
        for (int i = 0; i < WINDOW; i++) begin
            bits[i] = ((WINDOW * (WINDOW - 1 - i) - SX) < 0);
        end
        return bits;
    endfunction

    localparam t_rcp_tbl          RCP_TBL  = f_rcp_tbl();
    localparam t_coef_tbl         COEF_MAG = f_coef_mag();
    localparam logic [WINDOW-1:0] COEF_NEG = f_coef_neg();

endpackage

// ===== hdl/windowed_slope_tracker_core.sv =====
// Windowed least-squares slope tracker: sample window, smoothing, fit and scaling sequencer.
`timescale 1ns / 1ps

// Usage:
//   Input channel: i_sample with i_in_valid; the block answers with o_in_stall.
//   Each beat shifts one sample into a window of WINDOW entries. The first
//   WINDOW samples, and every WINDOW-1 samples after that, produce one result
//   beat (o_slope, o_direction) on the output channel; other samples produce none.
//   A sample that does not close a segment leaves the block idle; a new one is
//   taken in the next cycle.
//   A closing sample starts the sequencer around one shared multiplier:
//   smoothing, fit, then scaling and saturation. o_in_stall is high while
//   the sequencer runs, until the result is registered.
//   The result sits in an output register, so the next samples are taken while
//   the receiver holds i_out_stall; the sequencer waits only when it finishes a
//   slope while the previous result is still unclaimed.
//   Configuration: i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. Write only while idle. Unknown indexes are ignored.
//   Reset (synchronous, i_rst_n low) clears the window and fill count, drops
//   any pending result and restores flat_threshold = 0, slope_scale = 256.0.

module windowed_slope_tracker_core
    import wst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // sample channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SMP_W-1:0]     i_sample,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SLOPE_W-1:0]   o_slope,
    output logic [DIR_W-1:0]     o_direction,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCALE_W-1:0]   i_cfg_data
);

    // Control state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [THR_W-1:0]     r_thr, n_thr;
    logic [SCALE_W-1:0]   r_scale, n_scale;
    logic [Y_W-1:0]       r_win [WINDOW];
    logic [Y_W-1:0]       n_win [WINDOW];

    // Datapath registers
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [PROD_W-1:0]    r_prod;
    logic [SUM_W-1:0]     r_sum, n_sum;
    logic [NUM_W-1:0]     r_num, n_num;
    logic [NUM_W-1:0]     r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [SLOPE_W-1:0]   r_slope, n_slope;
    logic [DIR_W-1:0]     r_dir, n_dir;

    // Shared multiplier operands
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;

    // Helpers
    logic [WIN_IDX_W-1:0]             win_idx;
    logic [CHK_IDX_W-1:0]             chk_idx;
    logic                             win_last;
    logic [CNT_W-1:0]                 cnt_inc;
    logic [WIN_IDX_W:0]               sm_half;
    logic [SUM_W-1:0]                 sm_div;
    logic [Y_W-1:0]                   sm_q;
    logic [NUM_W-1:0]                 fit_term;
    logic [NCHUNK-1:0][CHUNK_W-1:0]   mag_pad;
    logic [RV_W-1:0]                  rv;
    logic                             sat_over;
    logic [SLOPE_W-1:0]               slope_mag;

    assign win_idx  = r_idx[WIN_IDX_W-1:0];
    assign chk_idx  = r_idx[CHK_IDX_W-1:0];
    assign win_last = (win_idx == WIN_IDX_W'(WINDOW - 1));
    assign cnt_inc  = r_cnt + CNT_W'(1);

    // Smoothing dividend: sum of smoothed entries so far + this entry + n/2
    assign sm_half  = ({1'b0, win_idx} + (WIN_IDX_W + 1)'(1)) >> 1;
    assign sm_div   = r_sum + SUM_W'(r_win[0]) + SUM_W'(sm_half);
    assign sm_q     = r_prod[RCP_K +: Y_W];

    assign fit_term = NUM_W'(r_prod);
    assign mag_pad  = MAG_PAD_W'(r_mag);

    // Saturation of the rounded magnitude
    assign rv = r_acc[ACC_W-1:RND_SH];
    always_comb begin
        if (r_neg) begin
            sat_over = (|rv[RV_W-1:SLOPE_W])
                     || (rv[SLOPE_W-1] && (|rv[SLOPE_W-2:0]));
        end else begin
            sat_over = |rv[RV_W-1:SLOPE_W-1];
        end
        if (sat_over) begin
            slope_mag = r_neg ? SLOPE_NEG_MAX : SLOPE_POS_MAX;
        end else begin
            slope_mag = rv[SLOPE_W-1:0];
        end
    end

    // Next state and datapath
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_thr       = r_thr;
        n_scale     = r_scale;
        n_win       = r_win;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_num       = r_num;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_slope     = r_slope;
        n_dir       = r_dir;
        mul_a       = '0;
        mul_b       = '0;

        // result beat taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // register writes
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLAT_THRESHOLD: n_thr   = i_cfg_data[THR_W-1:0];
                CFG_SLOPE_SCALE:    n_scale = i_cfg_data;
                default:            ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    for (int j = 1; j < WINDOW; j++) begin
                        n_win[j] = r_win[j-1];
                    end
                    n_win[0] = {i_sample, FRAC_W'(0)};
                    if (cnt_inc == CNT_W'(WINDOW)) begin
                        n_cnt   = CNT_W'(1);
                        n_idx   = '0;
                        n_sum   = '0;
                        n_state = S_SM_MUL;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
            end

            // entry i -> round((sum + y) / (i+1)) via reciprocal multiply
            S_SM_MUL: begin
                mul_a   = MUL_A_W'(sm_div);
                mul_b   = MUL_B_W'(RCP_TBL[win_idx]);
                n_state = S_SM_ACC;
            end

            S_SM_ACC: begin
                for (int j = 0; j < WINDOW - 1; j++) begin
                    n_win[j] = r_win[j+1];
                end
                n_win[WINDOW-1] = sm_q;
                n_sum           = r_sum + SUM_W'(sm_q);
                if (win_last) begin
                    n_idx   = '0;
                    n_num   = '0;
                    n_state = S_FIT_MUL;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_SM_MUL;
                end
            end

            // numerator = sum over entries of (W*x - sum x) * y
            S_FIT_MUL: begin
                mul_a   = MUL_A_W'(r_win[0]);
                mul_b   = MUL_B_W'(COEF_MAG[win_idx]);
                n_state = S_FIT_ACC;
            end

            S_FIT_ACC: begin
                for (int j = 0; j < WINDOW - 1; j++) begin
                    n_win[j] = r_win[j+1];
                end
                n_win[WINDOW-1] = r_win[0];
                if (COEF_NEG[win_idx]) begin
                    n_num = r_num - fit_term;
                end else begin
                    n_num = r_num + fit_term;
                end
                if (win_last) begin
                    n_state = S_ABS;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_FIT_MUL;
                end
            end

            S_ABS: begin
                n_neg   = r_num[NUM_W-1];
                n_mag   = r_num[NUM_W-1] ? (NUM_W'(0) - r_num) : r_num;
                n_acc   = '0;
                n_idx   = IDX_W'(NCHUNK - 1);
                n_state = S_SC_MUL;
            end

            // magnitude * scale, one 16-bit chunk per pass, top chunk first
            S_SC_MUL: begin
                mul_a   = MUL_A_W'(mag_pad[chk_idx]);
                mul_b   = MUL_B_W'(r_scale);
                n_state = S_SC_ACC;
            end

            S_SC_ACC: begin
                n_acc = {r_acc[ACC_W-CHUNK_W-1:0], CHUNK_W'(0)} + ACC_W'(r_prod);
                if (chk_idx == '0) begin
                    n_state = S_ROUND;
                end else begin
                    n_idx   = r_idx - IDX_W'(1);
                    n_state = S_SC_MUL;
                end
            end

            S_ROUND: begin
                n_acc   = r_acc + ROUND_HALF;
                n_state = S_DONE;
            end

            // saturate, classify, and load the output register when free
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_slope = r_neg ? (SLOPE_W'(0) - slope_mag) : slope_mag;
                    if (slope_mag < {1'b0, r_thr}) begin
                        n_dir = DIR_FLAT;
                    end else if (!r_neg && (slope_mag != '0)) begin
                        n_dir = DIR_POS;
                    end else begin
                        n_dir = DIR_NEG;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
            r_scale     <= SCALE_RESET;
            for (int j = 0; j < WINDOW; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_thr       <= n_thr;
            r_scale     <= n_scale;
            r_win       <= n_win;
        end
    end

    // Datapath registers, including the shared multiplier output
    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_idx   <= n_idx;
        r_sum   <= n_sum;
        r_num   <= n_num;
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_acc   <= n_acc;
        r_slope <= n_slope;
        r_dir   <= n_dir;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_slope     = r_slope;
    assign o_direction = r_dir;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== tb/windowed_slope_tracker_core_tb.sv =====
// Testbench for windowed_slope_tracker_core: queued sample driver, result monitor, slope predictor.
`timescale 1ns / 1ps

module windowed_slope_tracker_core_tb;
    import wst_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 6;
    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE       = 50;     // covers one sequencer pass
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 10;

    // Register indexes past the two real registers; writes to them are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        t_dir               dir;
    } t_slope_beat;

    // DUT ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [SMP_W-1:0]     i_sample    = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [SLOPE_W-1:0]   o_slope;
    logic [DIR_W-1:0]     o_direction;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [SCALE_W-1:0]   i_cfg_data  = '0;

    // Stimulus and scoreboard
    logic [SMP_W-1:0] sample_fifo [$];
    t_slope_beat      slope_q [$];
    logic             in_taken      = 1'b0;
    int               snd_idle_pct  = 0;
    int               rcv_idle_pct  = 0;
    int               mismatches    = 0;
    int               cycles        = 0;
    bit               hold_go       = 1'b0;
    bit               hold_used     = 1'b0;
    int               hold_left     = 0;

    // Tracker copy: window, fill count and registers
    logic [Y_W-1:0]   trk_win [WINDOW];
    logic [5:0]       trk_fill  = '0;
    logic [THR_W-1:0] trk_thr   = THR_RESET;
    logic [SCALE_W-1:0] trk_scale = SCALE_RESET;

    initial begin
        for (int i = 0; i < WINDOW; i++) trk_win[i] = '0;
    end

    windowed_slope_tracker_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_slope     (o_slope),
        .o_direction (o_direction),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shift one sample in; on a segment close, smooth, fit, scale and classify
    function automatic bit predict_slope(input logic [SMP_W-1:0] smp, output t_slope_beat beat);
        longint unsigned acc;
        longint unsigned run;
        longint unsigned mag;
        longint unsigned r;
        longint          num;
        bit              neg;
        beat = '0;
        for (int i = WINDOW - 1; i > 0; i--) trk_win[i] = trk_win[i-1];
        trk_win[0] = {smp, 8'h00};
        trk_fill = trk_fill + 6'd1;
        if (trk_fill != WINDOW) return 1'b0;
        trk_fill = 6'd1;

        // running mean over already-smoothed entries, round half up
        acc = 0;
        for (int i = 0; i < WINDOW; i++) begin
            run        = acc + trk_win[i];
            trk_win[i] = Y_W'((run + longint'((i + 1) / 2)) / longint'(i + 1));
            acc        = acc + trk_win[i];
        end

        // least-squares numerator, x runs oldest to newest
        num = 0;
        for (int x = 0; x < WINDOW; x++)
            num += longint'(WINDOW * x - SX) * longint'(trk_win[WINDOW-1-x]);

        // scale in two halves, magnitude rounded half away from zero
        neg = (num < 0);
        mag = neg ? -num : num;
        r   = mag * longint'(trk_scale[31:16])
            + ((mag * longint'(trk_scale[15:0]) + 64'd32768) >> 16);
        if (!neg && r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        if (neg && r > 64'h8000_0000) r = 64'h8000_0000;
        beat.slope = neg ? SLOPE_W'(-r) : SLOPE_W'(r);

        // zero slope is neither flat (at zero threshold) nor positive
        if (r < trk_thr) beat.dir = DIR_FLAT;
        else if (!neg && r != 0) beat.dir = DIR_POS;
        else beat.dir = DIR_NEG;
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        if (mismatches < MAX_SHOWN) $display("[%0t] ERROR: %s", $time, msg);
        mismatches++;
    endtask

    // Monitor: check result beats, then predict from sample beats and register writes
    always @(posedge i_clk) begin : monitor
        t_slope_beat got;
        t_slope_beat want;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.slope = o_slope;
            got.dir   = t_dir'(o_direction);
            if (slope_q.size() == 0) begin
                report_error($sformatf("unexpected result slope=%h dir=%0d",
                                       got.slope, got.dir));
            end else begin
                want = slope_q.pop_front();
                if (got.slope !== want.slope || got.dir !== want.dir)
                    report_error($sformatf("slope exp=%h got=%h  dir exp=%0d got=%0d",
                                           want.slope, got.slope, want.dir, got.dir));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (predict_slope(i_sample, want)) slope_q.push_back(want);
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FLAT_THRESHOLD: trk_thr   <= i_cfg_data[THR_W-1:0];
                CFG_SLOPE_SCALE:    trk_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample driver: next beat from the queue unless the sender idles
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (sample_fifo.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                i_in_valid <= 1'b1;
                i_sample   <= sample_fifo.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted once
    always @(negedge i_clk) begin
        if (hold_go && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver stall
    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("** windowed_slope_tracker_core: FAILED **");
            $finish;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait until every sample is in and every slope is out, then let the block settle
    task automatic wait_drained();
        while (sample_fifo.size() != 0 || i_in_valid || slope_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Mostly ramps with jitter, some plain noise and exact flat runs
    task automatic queue_random(input int count);
        int left;
        int len;
        int mode;
        int base;
        int step;
        int v;
        left = count;
        while (left > 0) begin
            mode = $urandom_range(0, 9);
            len  = $urandom_range(3, 14);
            if (len > left) len = left;
            base = $urandom_range(0, 65535);
            step = int'($urandom_range(0, 8000)) - 4000;
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0, 1:    v = $urandom_range(0, 65535);
                    2:       v = base;
                    default: v = base + step * k + int'($urandom_range(0, 400)) - 200;
                endcase
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                sample_fifo.push_back(v[SMP_W-1:0]);
            end
            left -= len;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: flat window, full-scale rise and fall, then random
        @(posedge i_clk);
        snd_idle_pct = 34;
        rcv_idle_pct = 51;
        repeat (WINDOW) sample_fifo.push_back(16'h0000);
        repeat (WINDOW - 1) sample_fifo.push_back(16'hFFFF);
        repeat (WINDOW - 1) sample_fifo.push_back(16'h0000);
        sample_fifo.push_back(16'd1);
        sample_fifo.push_back(16'd2);
        sample_fifo.push_back(16'd3);
        queue_random(130);
        wait_drained();

        // Top threshold with bit 31 set (masked off), tiny scale, spare indexes
        cfg_write(CFG_FLAT_THRESHOLD, 32'hFFFF_FFFF);
        cfg_write(CFG_SLOPE_SCALE, 32'h0000_0001);
        cfg_write(CFG_SPARE_2, $urandom());
        cfg_write(CFG_SPARE_3, $urandom());
        @(posedge i_clk);
        snd_idle_pct = 51;
        rcv_idle_pct = 34;
        queue_random(60);
        wait_drained();

        // Zero scale
        cfg_write(CFG_FLAT_THRESHOLD, $urandom_range(0, 65536));
        cfg_write(CFG_SLOPE_SCALE, 32'h0000_0000);
        @(posedge i_clk);
        queue_random(40);
        wait_drained();

        // Zero threshold, full scale, receiver held off so the block backs up
        cfg_write(CFG_FLAT_THRESHOLD, 32'h0000_0000);
        cfg_write(CFG_SLOPE_SCALE, 32'hFFFF_FFFF);
        @(posedge i_clk);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        queue_random(100);
        hold_go = 1'b1;
        wait_drained();

        // Mid-range threshold and scale
        cfg_write(CFG_FLAT_THRESHOLD, $urandom_range(0, 1 << 24));
        cfg_write(CFG_SLOPE_SCALE, $urandom_range(1 << 12, 1 << 18));
        @(posedge i_clk);
        queue_random(95);
        wait_drained();

        if (mismatches == 0 && slope_q.size() == 0) begin
            $display("** windowed_slope_tracker_core: PASSED **");
        end else begin
            $display("** windowed_slope_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/wst_pkg.sv
hdl/windowed_slope_tracker_core.sv
tb/windowed_slope_tracker_core_tb.sv
